FILE: rtl/assert_macros.svh
// Assertion macros used by the clause checker's top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that an expression holds at every clock edge outside reset.
`define CNFCC_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

// Checks that a condition at a clock edge implies an expression at that edge.
`define CNFCC_ASSERT_IMPLIES(label, cond, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (expr)) \
        else $error(msg);

`endif

FILE: rtl/cnfcc_pkg.sv
// Types, sizes and codes shared by the clause checker modules.
package cnfcc_pkg;

    localparam int unsigned C_MAX_VARS    = 4096;
    localparam int unsigned C_MAX_CLAUSES = 1048576;
    localparam int unsigned C_ADDR_W      = $clog2(C_MAX_VARS);
    localparam int unsigned C_PTR_W       = $clog2(C_MAX_VARS + 1);
    localparam int unsigned C_VAR_W       = 13;
    localparam int unsigned C_CNT_W       = 20;

    localparam logic [C_CNT_W-1:0] C_CNT_MAX = '1;
    localparam logic [C_CNT_W-1:0] C_IDX_LIMIT =
        ((C_MAX_CLAUSES - 1) < (2 ** C_CNT_W - 1)) ? C_CNT_W'(C_MAX_CLAUSES - 1) : '1;

    // Both queue depths must be powers of two so that the pointers wrap.
    localparam int unsigned C_CMDQ_DEPTH = 4;
    localparam int unsigned C_CMDQ_AW    = $clog2(C_CMDQ_DEPTH);
    localparam int unsigned C_RESQ_DEPTH = 2;
    localparam int unsigned C_RESQ_AW    = $clog2(C_RESQ_DEPTH);

    localparam logic [1:0] C_OP_LOAD  = 2'd0;
    localparam logic [1:0] C_OP_LIT   = 2'd1;
    localparam logic [1:0] C_OP_EMPTY = 2'd2;

    typedef enum logic [1:0] {
        CMD_LOAD,
        CMD_LIT,
        CMD_EMPTY
    } t_cmd_kind;

    typedef struct packed {
        logic [1:0]         opcode;
        logic               bit_value;
        logic [C_VAR_W-1:0] var_number;
        logic               negated;
        logic               last_literal;
    } t_in_item;

    typedef struct packed {
        logic [C_CNT_W-1:0] clause_index;
        logic               clause_sat;
        logic               clause_sat_flipped;
        logic [C_CNT_W-1:0] unsat_total;
        logic [C_CNT_W-1:0] flipped_unsat_total;
    } t_result;

    typedef struct packed {
        t_cmd_kind           kind;
        logic                bit_value;
        logic                in_range;
        logic [C_ADDR_W-1:0] addr;
        logic                negated;
        logic                last_literal;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_cmd_link;

endpackage

FILE: rtl/cnfcc_front.sv
// Front end: accepts items, decodes them into commands and queues them.
module cnfcc_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  cnfcc_pkg::t_in_item i_item,
    output cnfcc_pkg::t_cmd_link o_link,
    input  logic               i_pop
);
    import cnfcc_pkg::*;

    t_cmd                 slot_cmd;
    logic                 keep;
    logic                 enq;
    logic                 deq;
    t_cmd                 r_slots [C_CMDQ_DEPTH];
    logic [C_CMDQ_AW-1:0] r_wr;
    logic [C_CMDQ_AW-1:0] r_rd;
    logic [C_CMDQ_AW:0]   r_count;
    logic [C_CMDQ_AW-1:0] n_wr;
    logic [C_CMDQ_AW-1:0] n_rd;
    logic [C_CMDQ_AW:0]   n_count;

    always_comb begin
        slot_cmd.kind         = CMD_LIT;
        slot_cmd.bit_value    = i_item.bit_value;
        slot_cmd.in_range     = (i_item.var_number != '0) &&
                                (i_item.var_number <= C_VAR_W'(C_MAX_VARS));
        slot_cmd.addr         = C_ADDR_W'(i_item.var_number - C_VAR_W'(1));
        slot_cmd.negated      = i_item.negated;
        slot_cmd.last_literal = i_item.last_literal;
        keep                  = 1'b1;
        unique case (i_item.opcode)
            C_OP_LOAD: begin
                slot_cmd.kind = CMD_LOAD;
            end
            C_OP_LIT: begin
                slot_cmd.kind = CMD_LIT;
            end
            C_OP_EMPTY: begin
                slot_cmd.kind = CMD_EMPTY;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    assign full         = (r_count == (C_CMDQ_AW + 1)'(C_CMDQ_DEPTH));
    assign enq          = push && !full && keep;
    assign deq          = i_pop && o_link.valid;
    assign o_link.valid = (r_count != '0);
    assign o_link.cmd   = r_slots[r_rd];

    always_comb begin
        n_wr    = enq ? r_wr + 1'b1 : r_wr;
        n_rd    = deq ? r_rd + 1'b1 : r_rd;
        n_count = r_count + (C_CMDQ_AW + 1)'(enq) - (C_CMDQ_AW + 1)'(deq);
    end

    always_ff @(posedge i_clk) begin
        if (enq) begin
            r_slots[r_wr] <= slot_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

endmodule

FILE: rtl/cnfcc_back.sv
// Back end: variable store, literal evaluation, clause accumulators and counters.
module cnfcc_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  cnfcc_pkg::t_cmd_link i_link,
    output logic                 o_pop,
    output cnfcc_pkg::t_result   o_res,
    output logic                 o_res_push,
    input  logic                 i_res_full
);
    import cnfcc_pkg::*;

    logic                store [C_MAX_VARS];
    logic                r_rd_bit;
    logic [C_PTR_W-1:0]  r_load_ptr;
    logic [C_PTR_W-1:0]  n_load_ptr;
    logic                r_b_valid;
    t_cmd_kind           r_b_kind;
    logic                r_b_hit;
    logic                r_b_neg;
    logic                r_b_last;
    logic                n_b_valid;
    logic                r_or_plain;
    logic                r_or_flipped;
    logic                n_or_plain;
    logic                n_or_flipped;
    logic [C_CNT_W-1:0]  r_clause_cnt;
    logic [C_CNT_W-1:0]  r_unsat_cnt;
    logic [C_CNT_W-1:0]  r_flip_unsat_cnt;
    logic [C_CNT_W-1:0]  n_clause_cnt;
    logic [C_CNT_W-1:0]  n_unsat_cnt;
    logic [C_CNT_W-1:0]  n_flip_unsat_cnt;
    logic                lit;
    logic                acc_plain;
    logic                acc_flipped;
    logic                sat;
    logic                sat_f;
    logic                need_push;
    logic                b_done;
    logic                issue;
    logic                do_load;
    logic                hit;

    assign issue   = i_link.valid && (!r_b_valid || b_done);
    assign o_pop   = issue;
    assign do_load = issue && (i_link.cmd.kind == CMD_LOAD) &&
                     (r_load_ptr < C_PTR_W'(C_MAX_VARS));
    assign hit     = i_link.cmd.in_range &&
                     ({1'b0, i_link.cmd.addr} < (C_ADDR_W + 1)'(r_load_ptr));

    always_ff @(posedge i_clk) begin
        if (do_load) begin
            store[r_load_ptr[C_ADDR_W-1:0]] <= i_link.cmd.bit_value;
        end
        if (issue && (i_link.cmd.kind == CMD_LIT)) begin
            r_rd_bit <= store[i_link.cmd.addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_b_kind <= i_link.cmd.kind;
            r_b_hit  <= hit;
            r_b_neg  <= i_link.cmd.negated;
            r_b_last <= i_link.cmd.last_literal;
        end
    end

    always_comb begin
        lit         = (r_b_hit && r_rd_bit) ^ r_b_neg;
        acc_plain   = r_or_plain | lit;
        acc_flipped = r_or_flipped | ~lit;
        need_push   = r_b_valid && ((r_b_kind == CMD_EMPTY) || r_b_last);
        b_done      = r_b_valid && (!need_push || !i_res_full);
        sat         = (r_b_kind == CMD_LIT) && acc_plain;
        sat_f       = (r_b_kind == CMD_LIT) && acc_flipped;

        n_load_ptr       = do_load ? r_load_ptr + 1'b1 : r_load_ptr;
        n_b_valid        = issue ? (i_link.cmd.kind != CMD_LOAD) : (r_b_valid && !b_done);
        n_or_plain       = r_or_plain;
        n_or_flipped     = r_or_flipped;
        n_clause_cnt     = r_clause_cnt;
        n_unsat_cnt      = r_unsat_cnt;
        n_flip_unsat_cnt = r_flip_unsat_cnt;

        if (b_done && (r_b_kind == CMD_LIT)) begin
            n_or_plain   = r_b_last ? 1'b0 : acc_plain;
            n_or_flipped = r_b_last ? 1'b0 : acc_flipped;
        end
        if (b_done && need_push) begin
            if (!sat && (r_unsat_cnt != C_CNT_MAX)) begin
                n_unsat_cnt = r_unsat_cnt + 1'b1;
            end
            if (!sat_f && (r_flip_unsat_cnt != C_CNT_MAX)) begin
                n_flip_unsat_cnt = r_flip_unsat_cnt + 1'b1;
            end
            if (r_clause_cnt < C_IDX_LIMIT) begin
                n_clause_cnt = r_clause_cnt + 1'b1;
            end
        end

        o_res_push                = b_done && need_push;
        o_res.clause_index        = r_clause_cnt;
        o_res.clause_sat          = sat;
        o_res.clause_sat_flipped  = sat_f;
        o_res.unsat_total         = n_unsat_cnt;
        o_res.flipped_unsat_total = n_flip_unsat_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_ptr       <= '0;
            r_b_valid        <= 1'b0;
            r_or_plain       <= 1'b0;
            r_or_flipped     <= 1'b0;
            r_clause_cnt     <= '0;
            r_unsat_cnt      <= '0;
            r_flip_unsat_cnt <= '0;
        end else begin
            r_load_ptr       <= n_load_ptr;
            r_b_valid        <= n_b_valid;
            r_or_plain       <= n_or_plain;
            r_or_flipped     <= n_or_flipped;
            r_clause_cnt     <= n_clause_cnt;
            r_unsat_cnt      <= n_unsat_cnt;
            r_flip_unsat_cnt <= n_flip_unsat_cnt;
        end
    end

endmodule

FILE: rtl/cnfcc_res_queue.sv
// Result queue that holds finished clause items until they are popped.
module cnfcc_res_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  cnfcc_pkg::t_result i_res,
    output logic               o_full,
    output logic               empty,
    input  logic               pop,
    output cnfcc_pkg::t_result o_result
);
    import cnfcc_pkg::*;

    t_result              r_slots [C_RESQ_DEPTH];
    logic [C_RESQ_AW-1:0] r_wr;
    logic [C_RESQ_AW-1:0] r_rd;
    logic [C_RESQ_AW:0]   r_count;
    logic                 enq;
    logic                 deq;

    assign o_full   = (r_count == (C_RESQ_AW + 1)'(C_RESQ_DEPTH));
    assign empty    = (r_count == '0);
    assign enq      = i_push && !o_full;
    assign deq      = pop && !empty;
    assign o_result = r_slots[r_rd];

    always_ff @(posedge i_clk) begin
        if (enq) begin
            r_slots[r_wr] <= i_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (enq) begin
                r_wr <= r_wr + 1'b1;
            end
            if (deq) begin
                r_rd <= r_rd + 1'b1;
            end
            r_count <= r_count + (C_RESQ_AW + 1)'(enq) - (C_RESQ_AW + 1)'(deq);
        end
    end

endmodule

FILE: rtl/cnf_clause_checker_core.sv
// Top level of the CNF clause checker: front end, back end and result queue.
//
//   Channel   Handshake     Payload     Direction
//   items     push / full   i_item      in
//   results   empty / pop   o_result    out
//
// An item is registered in the command queue and, unless it is a load, in the back end's read stage;
// one item per cycle is sustained while the result queue has room, since each item needs at most one store access.
// A finished clause passes the command queue, the back end's read stage and the result queue before it can be popped.
// Reset clears all control state and counters; the store needs no clearing pass,
// since entries at or above the load count read as false.
// A full result queue stalls the back end, and the command queue then fills and raises full.
module cnf_clause_checker_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  cnfcc_pkg::t_in_item i_item,
    output logic                empty,
    input  logic                pop,
    output cnfcc_pkg::t_result  o_result
);
    import cnfcc_pkg::*;

    `include "assert_macros.svh"

    t_cmd_link link;
    logic      cmd_pop;
    t_result   res;
    logic      res_push;
    logic      res_full;
    logic      res_unsat_both;
    logic      res_counted_both;

    cnfcc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .full    (full),
        .i_item  (i_item),
        .o_link  (link),
        .i_pop   (cmd_pop)
    );

    cnfcc_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_link     (link),
        .o_pop      (cmd_pop),
        .o_res      (res),
        .o_res_push (res_push),
        .i_res_full (res_full)
    );

    cnfcc_res_queue u_res_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (res_push),
        .i_res    (res),
        .o_full   (res_full),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result)
    );

    assign res_unsat_both   = res_push && !res.clause_sat && !res.clause_sat_flipped;
    assign res_counted_both = (res.unsat_total != '0) && (res.flipped_unsat_total != '0);

    `CNFCC_ASSERT_IMPLIES(a_res_push_room, res_push, !res_full, "result pushed into a full queue")
    `CNFCC_ASSERT_IMPLIES(a_cmd_pop_valid, cmd_pop, link.valid, "pop from empty command queue")
    `CNFCC_ASSERT_IMPLIES(a_empty_clause_unsat, res_unsat_both, res_counted_both, "not counted")

endmodule
